@@ sv/number_literal_lexer_assert.svh @@
// ---------------------------------------------------------------------------
// number_literal_lexer assertion macros
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef NUMBER_LITERAL_LEXER_ASSERT_SVH
`define NUMBER_LITERAL_LEXER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define NLL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("number_literal_lexer assertion failed");

// antecedent implies consequent in the next cycle
`define NLL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("number_literal_lexer assertion failed");

`endif

@@ sv/nll_pkg.sv @@
// ---------------------------------------------------------------------------
// nll_pkg
// types, character codes and scanner state shared by the literal lexer
// ---------------------------------------------------------------------------
package nll_pkg;

    localparam int MAX_COUNT = 255;
    localparam int COUNT_W   = $clog2(MAX_COUNT + 1);
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_COUNT);

    // scan phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_ZERO  = 3'd1;
    localparam logic [2:0] PH_INT   = 3'd2;
    localparam logic [2:0] PH_FRAC  = 3'd3;
    localparam logic [2:0] PH_ESIGN = 3'd4;
    localparam logic [2:0] PH_EDIG  = 3'd5;
    localparam logic [2:0] PH_BASED = 3'd6;

    // bases
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_BIN = 2'd2;
    localparam logic [1:0] BASE_OCT = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_PREFIX = 2'd1;
    localparam logic [1:0] ERR_EMPTY  = 2'd2;
    localparam logic [1:0] ERR_DIGIT  = 2'd3;

    // exponent sign codes
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd2;

    // flag bit positions
    localparam int FL_POINT = 0;
    localparam int FL_EXP   = 1;
    localparam int FL_PLUS  = 2;
    localparam int FL_MINUS = 3;

    // characters
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    typedef struct packed {
        logic [2:0]         phase;
        logic [1:0]         base;
        logic [COUNT_W-1:0] int_cnt;
        logic [COUNT_W-1:0] frac_cnt;
        logic [COUNT_W-1:0] exp_cnt;
        logic [COUNT_W-1:0] total_cnt;
        logic [3:0]         flags;
        logic [1:0]         err_code;
        logic [7:0]         err_off;
        logic               lead_nz;
    } state_t;

    // packed from the lowest bit up: base first, error_offset last
    typedef struct packed {
        logic [7:0] error_offset;
        logic [1:0] error_code;
        logic [7:0] literal_length;
        logic [7:0] exp_digits;
        logic [1:0] exp_sign;
        logic       has_exponent;
        logic [7:0] frac_digits;
        logic       has_point;
        logic [7:0] int_digits;
        logic [1:0] base;
    } result_t;

    typedef struct packed {
        state_t  nxt;
        logic    emit;
        result_t res;
    } step_t;

    localparam state_t STATE_INIT = '{
        phase:     PH_START,
        base:      BASE_DEC,
        int_cnt:   '0,
        frac_cnt:  '0,
        exp_cnt:   '0,
        total_cnt: '0,
        flags:     4'd0,
        err_code:  ERR_NONE,
        err_off:   8'd0,
        lead_nz:   1'b0
    };

    function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
        return (v >= MAX_CNT) ? MAX_CNT : v + COUNT_W'(1);
    endfunction

    function automatic logic [7:0] clamp8(logic [COUNT_W-1:0] v);
        return (32'(v) > 32'd255) ? 8'hff : 8'(v);
    endfunction

endpackage

@@ sv/nll_step.sv @@
// ---------------------------------------------------------------------------
// nll_step
// one character step of the literal scanner: next state and optional result
// ---------------------------------------------------------------------------
module nll_step (
    input  nll_pkg::state_t st,
    input  logic [7:0]      ch,
    output nll_pkg::step_t  step
);

    function automatic nll_pkg::result_t make_result(nll_pkg::state_t s, logic [1:0] code,
                                                     logic [7:0] off);
        nll_pkg::result_t r;
        r.base           = s.base;
        r.int_digits     = nll_pkg::clamp8(s.int_cnt);
        r.has_point      = s.flags[nll_pkg::FL_POINT];
        r.frac_digits    = nll_pkg::clamp8(s.frac_cnt);
        r.has_exponent   = s.flags[nll_pkg::FL_EXP];
        r.exp_sign       = s.flags[nll_pkg::FL_MINUS] ? nll_pkg::SIGN_MINUS :
                           (s.flags[nll_pkg::FL_PLUS] ? nll_pkg::SIGN_PLUS : nll_pkg::SIGN_NONE);
        r.exp_digits     = nll_pkg::clamp8(s.exp_cnt);
        r.literal_length = nll_pkg::clamp8(s.total_cnt);
        r.error_code     = code;
        r.error_offset   = (code == nll_pkg::ERR_NONE) ? 8'd0 : off;
        return r;
    endfunction

    function automatic nll_pkg::step_t do_emit(nll_pkg::state_t s, logic [1:0] code,
                                               logic [7:0] off);
        nll_pkg::step_t r;
        r.nxt  = nll_pkg::STATE_INIT;
        r.emit = 1'b1;
        r.res  = make_result(s, code, off);
        return r;
    endfunction

    function automatic logic is_dec(logic [7:0] c);
        return (c >= nll_pkg::CH_0) && (c <= nll_pkg::CH_9);
    endfunction

    function automatic nll_pkg::step_t hold(nll_pkg::state_t s);
        nll_pkg::step_t r;
        r.nxt  = s;
        r.emit = 1'b0;
        r.res  = '0;
        return r;
    endfunction

    // first non-digit after the integer part
    function automatic nll_pkg::step_t after_int(nll_pkg::state_t s, logic [7:0] c);
        nll_pkg::step_t r;
        logic [7:0]     low;
        r   = hold(s);
        low = c | nll_pkg::CH_CASE;
        if (low == nll_pkg::CH_LC_E)
        begin
            r.nxt.flags[nll_pkg::FL_EXP] = 1'b1;
            r.nxt.phase = nll_pkg::PH_ESIGN;
        end
        else if (low == nll_pkg::CH_LC_X)
        begin
            r.nxt.base  = nll_pkg::BASE_HEX;
            r.nxt.phase = nll_pkg::PH_BASED;
        end
        else if (low == nll_pkg::CH_LC_B)
        begin
            r.nxt.base  = nll_pkg::BASE_BIN;
            r.nxt.phase = nll_pkg::PH_BASED;
        end
        else if (c == nll_pkg::CH_DOT)
        begin
            r.nxt.flags[nll_pkg::FL_POINT] = 1'b1;
            r.nxt.phase = nll_pkg::PH_FRAC;
        end
        else
        begin
            return do_emit(s, nll_pkg::ERR_NONE, 8'd0);
        end
        r.nxt.total_cnt = nll_pkg::sat_inc(s.total_cnt);
        return r;
    endfunction

    // digits after a base prefix or a leading zero
    function automatic nll_pkg::step_t based_char(nll_pkg::state_t s, logic [7:0] c);
        nll_pkg::step_t r;
        logic [7:0]     low;
        logic           bad;
        r   = hold(s);
        low = c | nll_pkg::CH_CASE;
        bad = 1'b0;
        if (is_dec(c) || ((low >= nll_pkg::CH_LC_A) && (low <= nll_pkg::CH_LC_F)))
        begin
            if (s.err_code == nll_pkg::ERR_NONE)
            begin
                if (s.base == nll_pkg::BASE_BIN)
                    bad = (c != nll_pkg::CH_0) && (c != nll_pkg::CH_1);
                else if (s.base == nll_pkg::BASE_OCT)
                    bad = !((c >= nll_pkg::CH_0) && (c <= nll_pkg::CH_7));
                if (bad)
                begin
                    r.nxt.err_code = nll_pkg::ERR_DIGIT;
                    r.nxt.err_off  = nll_pkg::clamp8(s.total_cnt);
                end
            end
            r.nxt.frac_cnt  = nll_pkg::sat_inc(s.frac_cnt);
            r.nxt.total_cnt = nll_pkg::sat_inc(s.total_cnt);
            return r;
        end
        if ((s.int_cnt != nll_pkg::COUNT_W'(1)) || ((s.frac_cnt != '0) && s.lead_nz))
            return do_emit(s, nll_pkg::ERR_PREFIX, nll_pkg::clamp8(s.int_cnt));
        if (s.frac_cnt == '0)
            return do_emit(s, nll_pkg::ERR_EMPTY, nll_pkg::clamp8(s.int_cnt));
        if (s.err_code != nll_pkg::ERR_NONE)
            return do_emit(s, s.err_code, s.err_off);
        return do_emit(s, nll_pkg::ERR_NONE, 8'd0);
    endfunction

    nll_pkg::state_t s_oct;

    always_comb
    begin
        s_oct       = st;
        s_oct.base  = nll_pkg::BASE_OCT;
        s_oct.phase = nll_pkg::PH_BASED;
        step        = hold(st);
        unique case (st.phase) inside
            nll_pkg::PH_ZERO:
            begin
                if (is_dec(ch))
                    step = based_char(s_oct, ch);
                else
                    step = after_int(st, ch);
            end
            nll_pkg::PH_INT:
            begin
                if (is_dec(ch))
                begin
                    step.nxt.int_cnt   = nll_pkg::sat_inc(st.int_cnt);
                    step.nxt.total_cnt = nll_pkg::sat_inc(st.total_cnt);
                end
                else
                    step = after_int(st, ch);
            end
            nll_pkg::PH_FRAC:
            begin
                if (is_dec(ch))
                begin
                    step.nxt.frac_cnt  = nll_pkg::sat_inc(st.frac_cnt);
                    step.nxt.total_cnt = nll_pkg::sat_inc(st.total_cnt);
                end
                else if ((ch | nll_pkg::CH_CASE) == nll_pkg::CH_LC_E)
                begin
                    step.nxt.flags[nll_pkg::FL_EXP] = 1'b1;
                    step.nxt.phase     = nll_pkg::PH_ESIGN;
                    step.nxt.total_cnt = nll_pkg::sat_inc(st.total_cnt);
                end
                else
                    step = do_emit(st, nll_pkg::ERR_NONE, 8'd0);
            end
            nll_pkg::PH_ESIGN, nll_pkg::PH_EDIG:
            begin
                if ((st.phase == nll_pkg::PH_ESIGN) &&
                    ((ch == nll_pkg::CH_PLUS) || (ch == nll_pkg::CH_MINUS)))
                begin
                    if (ch == nll_pkg::CH_PLUS)
                        step.nxt.flags[nll_pkg::FL_PLUS] = 1'b1;
                    else
                        step.nxt.flags[nll_pkg::FL_MINUS] = 1'b1;
                    step.nxt.phase     = nll_pkg::PH_EDIG;
                    step.nxt.total_cnt = nll_pkg::sat_inc(st.total_cnt);
                end
                else if (is_dec(ch))
                begin
                    step.nxt.phase     = nll_pkg::PH_EDIG;
                    step.nxt.exp_cnt   = nll_pkg::sat_inc(st.exp_cnt);
                    step.nxt.total_cnt = nll_pkg::sat_inc(st.total_cnt);
                end
                else
                    step = do_emit(st, nll_pkg::ERR_NONE, 8'd0);
            end
            nll_pkg::PH_BASED:
            begin
                step = based_char(st, ch);
            end
            default:
            begin
                // start of literal, also any unused phase code
                step.nxt = nll_pkg::STATE_INIT;
                if (is_dec(ch))
                begin
                    step.nxt.int_cnt   = nll_pkg::COUNT_W'(1);
                    step.nxt.total_cnt = nll_pkg::COUNT_W'(1);
                    step.nxt.lead_nz   = (ch != nll_pkg::CH_0);
                    step.nxt.phase     = (ch == nll_pkg::CH_0) ? nll_pkg::PH_ZERO
                                                               : nll_pkg::PH_INT;
                end
                else if (ch == nll_pkg::CH_DOT)
                begin
                    step.nxt.flags[nll_pkg::FL_POINT] = 1'b1;
                    step.nxt.total_cnt = nll_pkg::COUNT_W'(1);
                    step.nxt.phase     = nll_pkg::PH_FRAC;
                end
                else
                    step = do_emit(nll_pkg::STATE_INIT, nll_pkg::ERR_PREFIX, 8'd0);
            end
        endcase
    end

endmodule

@@ sv/number_literal_lexer.sv @@
// ---------------------------------------------------------------------------
// number_literal_lexer
// scans one character per transfer and reports each numeric literal
//
// channel   dir   payload
// s_*       in    tdata[7:0] ch
// m_*       out   tdata[47:0] one result per finished literal
//
// one character per cycle, sustained while results are taken; the scanner state
// update is one pass through nll_step between the input register and the
// result register; the character that ends a literal is taken into the input
// register, then its result into the result register; it is not part of the literal
// reset clears the scanner to the start of a literal, no clearing pass
// a stalled result holds the input register; s_tready drops only while both
// the input register and the result register are full and m_tready is low
// ---------------------------------------------------------------------------
module number_literal_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    output logic        m_tvalid,
    input  logic        m_tready,
    // base[1:0], int_digits[9:2], has_point[10], frac_digits[18:11],
    // has_exponent[19], exp_sign[21:20], exp_digits[29:22],
    // literal_length[37:30], error_code[39:38], error_offset[47:40]
    output logic [47:0] m_tdata
);

    logic             in_valid_reg;
    logic [7:0]       in_ch_reg;
    nll_pkg::state_t  st_reg;
    logic             out_valid_reg;
    nll_pkg::result_t res_reg;
    nll_pkg::step_t   step;
    logic             advance;

    nll_step u_step (
        .st   (st_reg),
        .ch   (in_ch_reg),
        .step (step)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= nll_pkg::STATE_INIT;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && step.emit;
                if (in_valid_reg)
                    st_reg <= step.nxt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_ch_reg <= s_tdata;
        if (advance && in_valid_reg && step.emit)
            res_reg <= step.res;
    end

`include "number_literal_lexer_assert.svh"

    `NLL_ASSERT_NEXT(a_in_load, s_tvalid && s_tready, in_valid_reg)
    `NLL_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg && $stable(in_ch_reg))
    `NLL_ASSERT_NEXT(a_emit_shows, advance && in_valid_reg && step.emit, m_tvalid)
    `NLL_ASSERT_SAME(a_start_clean, st_reg.phase == nll_pkg::PH_START,
                     st_reg.total_cnt == '0 && st_reg.int_cnt == '0)
    `NLL_ASSERT_SAME(a_ok_offset, m_tvalid && res_reg.error_code == nll_pkg::ERR_NONE,
                     res_reg.error_offset == 8'd0)

endmodule

@@ sim/tb_number_literal_lexer.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_number_literal_lexer
// streams text into the lexer one character per transfer and predicts every
// literal it reports: base, part lengths, flags, length and error with its
// offset; directed cases first, then random literals, well-formed for the
// most part, with broken prefixes and noise, under random gaps and stalls
// ---------------------------------------------------------------------------
module tb_number_literal_lexer;

    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SEMI  = 8'h3b;

    class literal_tracker;
        logic [2:0]       scan_ph;
        logic [1:0]       radix;
        logic [7:0]       int_cnt;
        logic [7:0]       frac_cnt;
        logic [7:0]       exp_cnt;
        logic [7:0]       total_cnt;
        logic [3:0]       seen;
        logic [1:0]       err_code;
        logic [7:0]       err_off;
        logic             lead_nz;
        nll_pkg::result_t pending_literals[$];
        int               mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        local function void restart();
            scan_ph   = nll_pkg::PH_START;
            radix     = nll_pkg::BASE_DEC;
            int_cnt   = 8'd0;
            frac_cnt  = 8'd0;
            exp_cnt   = 8'd0;
            total_cnt = 8'd0;
            seen      = 4'd0;
            err_code  = nll_pkg::ERR_NONE;
            err_off   = 8'd0;
            lead_nz   = 1'b0;
        endfunction

        local function logic [7:0] bump(logic [7:0] v);
            return (v >= nll_pkg::MAX_CNT) ? v : v + 8'd1;
        endfunction

        local function void close_literal(logic [1:0] code, logic [7:0] off);
            nll_pkg::result_t r;
            r.base           = radix;
            r.int_digits     = int_cnt;
            r.has_point      = seen[nll_pkg::FL_POINT];
            r.frac_digits    = frac_cnt;
            r.has_exponent   = seen[nll_pkg::FL_EXP];
            r.exp_sign       = seen[nll_pkg::FL_MINUS] ? nll_pkg::SIGN_MINUS :
                               (seen[nll_pkg::FL_PLUS] ? nll_pkg::SIGN_PLUS
                                                       : nll_pkg::SIGN_NONE);
            r.exp_digits     = exp_cnt;
            r.literal_length = total_cnt;
            r.error_code     = code;
            r.error_offset   = (code == nll_pkg::ERR_NONE) ? 8'd0 : off;
            pending_literals.push_back(r);
            restart();
        endfunction

        // first non-digit after the integer part
        local function void after_integer(logic [7:0] c);
            logic [7:0] low;
            low = c | nll_pkg::CH_CASE;
            if (low == nll_pkg::CH_LC_E)
            begin
                seen[nll_pkg::FL_EXP] = 1'b1;
                scan_ph = nll_pkg::PH_ESIGN;
            end
            else if (low == nll_pkg::CH_LC_X)
            begin
                radix = nll_pkg::BASE_HEX;
                scan_ph = nll_pkg::PH_BASED;
            end
            else if (low == nll_pkg::CH_LC_B)
            begin
                radix = nll_pkg::BASE_BIN;
                scan_ph = nll_pkg::PH_BASED;
            end
            else if (c == nll_pkg::CH_DOT)
            begin
                seen[nll_pkg::FL_POINT] = 1'b1;
                scan_ph = nll_pkg::PH_FRAC;
            end
            else
            begin
                close_literal(nll_pkg::ERR_NONE, 8'd0);
                return;
            end
            total_cnt = bump(total_cnt);
        endfunction

        local function void based_digit(logic [7:0] c);
            logic [7:0] low;
            logic       bad;
            low = c | nll_pkg::CH_CASE;
            if ((c >= nll_pkg::CH_0 && c <= nll_pkg::CH_9) ||
                (low >= nll_pkg::CH_LC_A && low <= nll_pkg::CH_LC_F))
            begin
                if (err_code == nll_pkg::ERR_NONE)
                begin
                    bad = 1'b0;
                    if (radix == nll_pkg::BASE_BIN)
                        bad = (c != nll_pkg::CH_0 && c != nll_pkg::CH_1);
                    else if (radix == nll_pkg::BASE_OCT)
                        bad = !(c >= nll_pkg::CH_0 && c <= nll_pkg::CH_7);
                    if (bad)
                    begin
                        err_code = nll_pkg::ERR_DIGIT;
                        err_off  = total_cnt;
                    end
                end
                frac_cnt  = bump(frac_cnt);
                total_cnt = bump(total_cnt);
            end
            else if (int_cnt != 8'd1 || (frac_cnt != 8'd0 && lead_nz))
                close_literal(nll_pkg::ERR_PREFIX, int_cnt);
            else if (frac_cnt == 8'd0)
                close_literal(nll_pkg::ERR_EMPTY, int_cnt);
            else
                close_literal(err_code, err_off);
        endfunction

        function void take_char(logic [7:0] c);
            logic is_dig;
            is_dig = (c >= nll_pkg::CH_0 && c <= nll_pkg::CH_9);
            case (scan_ph) inside
                nll_pkg::PH_ZERO:
                begin
                    if (is_dig)
                    begin
                        radix = nll_pkg::BASE_OCT;
                        scan_ph = nll_pkg::PH_BASED;
                        based_digit(c);
                    end
                    else
                        after_integer(c);
                end
                nll_pkg::PH_INT:
                begin
                    if (is_dig)
                    begin
                        int_cnt   = bump(int_cnt);
                        total_cnt = bump(total_cnt);
                    end
                    else
                        after_integer(c);
                end
                nll_pkg::PH_FRAC:
                begin
                    if (is_dig)
                    begin
                        frac_cnt  = bump(frac_cnt);
                        total_cnt = bump(total_cnt);
                    end
                    else if ((c | nll_pkg::CH_CASE) == nll_pkg::CH_LC_E)
                    begin
                        seen[nll_pkg::FL_EXP] = 1'b1;
                        scan_ph = nll_pkg::PH_ESIGN;
                        total_cnt = bump(total_cnt);
                    end
                    else
                        close_literal(nll_pkg::ERR_NONE, 8'd0);
                end
                nll_pkg::PH_ESIGN, nll_pkg::PH_EDIG:
                begin
                    if (scan_ph == nll_pkg::PH_ESIGN &&
                        (c == nll_pkg::CH_PLUS || c == nll_pkg::CH_MINUS))
                    begin
                        seen[(c == nll_pkg::CH_PLUS) ? nll_pkg::FL_PLUS
                                                     : nll_pkg::FL_MINUS] = 1'b1;
                        scan_ph = nll_pkg::PH_EDIG;
                        total_cnt = bump(total_cnt);
                    end
                    else
                    begin
                        scan_ph = nll_pkg::PH_EDIG;
                        if (is_dig)
                        begin
                            exp_cnt   = bump(exp_cnt);
                            total_cnt = bump(total_cnt);
                        end
                        else
                            close_literal(nll_pkg::ERR_NONE, 8'd0);
                    end
                end
                nll_pkg::PH_BASED:
                    based_digit(c);
                default:
                begin
                    restart();
                    if (is_dig)
                    begin
                        int_cnt   = 8'd1;
                        total_cnt = 8'd1;
                        lead_nz   = (c != nll_pkg::CH_0);
                        scan_ph   = (c == nll_pkg::CH_0) ? nll_pkg::PH_ZERO
                                                         : nll_pkg::PH_INT;
                    end
                    else if (c == nll_pkg::CH_DOT)
                    begin
                        seen[nll_pkg::FL_POINT] = 1'b1;
                        total_cnt = 8'd1;
                        scan_ph   = nll_pkg::PH_FRAC;
                    end
                    else
                        close_literal(nll_pkg::ERR_PREFIX, 8'd0);
                end
            endcase
        endfunction

        local function string show(nll_pkg::result_t r);
            return {$sformatf("base=%0d int=%0d pt=%0d frac=%0d ex=%0d ",
                              r.base, r.int_digits, r.has_point, r.frac_digits,
                              r.has_exponent),
                    $sformatf("sign=%0d edig=%0d len=%0d err=%0d off=%0d",
                              r.exp_sign, r.exp_digits, r.literal_length,
                              r.error_code, r.error_offset)};
        endfunction

        function void match_literal(nll_pkg::result_t got);
            nll_pkg::result_t want;
            if (pending_literals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected literal result: %s", show(got));
            end
            else
            begin
                want = pending_literals.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("literal mismatch\n  expected %s\n  actual   %s",
                                 show(want), show(got));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // ch
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // base, int_digits, has_point, frac_digits, has_exponent,
                            // exp_sign, exp_digits, literal_length, error_code,
                            // error_offset

    bit             src_gaps;
    bit             snk_gaps;
    int             chars_sent;
    int             cycle_count;
    logic [7:0]     lit_text[$];
    literal_tracker tracker = new();

    number_literal_lexer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_number_literal_lexer: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.match_literal(nll_pkg::result_t'(m_tdata));
    end

    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (snk_gaps && $urandom_range(3, 0) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 1)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    function automatic logic [7:0] any_case(logic [7:0] c);
        return $urandom_range(1, 0) ? c : (c & ~nll_pkg::CH_CASE);
    endfunction

    function automatic logic [7:0] dec_char(int lo, int hi);
        return nll_pkg::CH_0 + 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] hex_char();
        if ($urandom_range(1, 0))
            return dec_char(0, 9);
        return any_case(nll_pkg::CH_LC_A + 8'($urandom_range(5, 0)));
    endfunction

    // rare runs long enough to saturate the counters
    function automatic int run_len(bit stretch);
        if (stretch || $urandom_range(399, 0) == 0)
            return $urandom_range(264, 256);
        return $urandom_range(5, 0);
    endfunction

    function automatic logic [7:0] stop_char();
        case ($urandom_range(6, 0))
            0: return CH_SP;
            1: return CH_SEMI;
            2: return CH_COMMA;
            3: return CH_RPAR;
            4: return CH_LF;
            5: return CH_NUL;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic void push_digits(int lo, int hi, int n);
        repeat (n) lit_text.push_back(dec_char(lo, hi));
    endfunction

    function automatic void push_exponent(bit stretch);
        int sign_sel;
        lit_text.push_back(any_case(nll_pkg::CH_LC_E));
        sign_sel = stretch ? 2 : $urandom_range(2, 0);
        if (sign_sel == 1)
            lit_text.push_back(nll_pkg::CH_PLUS);
        else if (sign_sel == 2)
            lit_text.push_back(nll_pkg::CH_MINUS);
        push_digits(0, 9, run_len(stretch));
    endfunction

    task automatic send_char(input logic [7:0] c);
        if (src_gaps && $urandom_range(3, 0) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.take_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_literal(input bit stretch);
        int kind;
        lit_text.delete();
        kind = stretch ? 0 : $urandom_range(9, 0);
        case (kind) inside
            0, 1, 2:
            begin
                lit_text.push_back(dec_char(1, 9));
                push_digits(0, 9, run_len(stretch));
                if (stretch || $urandom_range(1, 0))
                begin
                    lit_text.push_back(nll_pkg::CH_DOT);
                    push_digits(0, 9, run_len(stretch));
                end
                if (stretch || $urandom_range(1, 0))
                    push_exponent(stretch);
            end
            3:
            begin
                lit_text.push_back(nll_pkg::CH_DOT);
                push_digits(0, 9, run_len(1'b0));
                if ($urandom_range(1, 0))
                    push_exponent(1'b0);
            end
            4:
            begin
                lit_text.push_back(nll_pkg::CH_0);
                lit_text.push_back(any_case(nll_pkg::CH_LC_X));
                repeat (run_len(1'b0)) lit_text.push_back(hex_char());
            end
            5:
            begin
                lit_text.push_back(nll_pkg::CH_0);
                lit_text.push_back(any_case(nll_pkg::CH_LC_B));
                repeat (run_len(1'b0))
                    lit_text.push_back(($urandom_range(15, 0) == 0) ? hex_char()
                                                                     : dec_char(0, 1));
            end
            6:
            begin
                lit_text.push_back(nll_pkg::CH_0);
                repeat (run_len(1'b0) + 1)
                    lit_text.push_back(($urandom_range(15, 0) == 0) ? hex_char()
                                                                     : dec_char(0, 7));
            end
            7:
            begin
                push_digits(0, 9, $urandom_range(3, 1));
                lit_text.push_back(any_case($urandom_range(1, 0) ? nll_pkg::CH_LC_X
                                                                 : nll_pkg::CH_LC_B));
                repeat (run_len(1'b0)) lit_text.push_back(hex_char());
            end
            8:
                repeat ($urandom_range(4, 1)) lit_text.push_back(8'($urandom_range(255, 0)));
            default:
            begin
                lit_text.push_back(nll_pkg::CH_0);
                case ($urandom_range(2, 0))
                    1:
                    begin
                        lit_text.push_back(nll_pkg::CH_DOT);
                        push_digits(0, 9, run_len(1'b0));
                    end
                    2: push_exponent(1'b0);
                    default: ;
                endcase
            end
        endcase
        lit_text.push_back(stop_char());
        foreach (lit_text[i])
            send_char(lit_text[i]);
    endtask

    initial
    begin
        int         next_switch;
        bit         first_lit;
        logic [1:0] mode;

        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= CH_NUL;
        cycle_count <= 0;
        src_gaps    = 1'b0;
        snk_gaps    = 1'b0;
        chars_sent  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_gaps = 1'b1;
        snk_gaps = 1'b1;
        send_char(CH_NUL);      // end of text where a literal should start
        send_text("0xAf;");
        send_text("0b2;");      // bad binary digit
        send_text("079 ");      // bad octal digit
        send_text("0x ");       // prefix with no digits
        send_text("5b1 ");      // nonzero lead before base letter
        send_text(".5e+2 ");
        send_text("1e- ");      // exponent with no digits

        next_switch = 0;
        first_lit   = 1'b1;
        while (chars_sent < ITEM_TARGET)
        begin
            if (chars_sent >= next_switch)
            begin
                mode        = 2'($urandom_range(3, 0));
                src_gaps    = mode[0];
                snk_gaps    = mode[1];
                next_switch = chars_sent + 200;
            end
            if (chars_sent > ITEM_TARGET - 300)
            begin
                src_gaps = 1'b0;
                snk_gaps = 1'b0;
            end
            send_literal(first_lit);
            first_lit = 1'b0;
        end
        // close whatever literal is still open
        send_char(CH_SP);
        s_tvalid <= 1'b0;

        while (tracker.pending_literals.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_literals.size() == 0)
            $display("tb_number_literal_lexer: clean");
        else
            $display("tb_number_literal_lexer: errors");
        $finish;
    end
endmodule
